>>> hw/rtl/gnq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnq_pkg
// Shared constants, types and command codes for the grid neighbourhood query.
// ----------------------------------------------------------------------------
package gnq_pkg;

	// Grid geometry and field widths
	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int CELL_BITS  = 8;
	localparam int X_BITS     = $clog2(MAX_WIDTH);
	localparam int Y_BITS     = $clog2(MAX_HEIGHT);
	localparam int ADDR_BITS  = X_BITS + Y_BITS;
	localparam int DIM_BITS   = 7;
	localparam int ANS_BITS   = 12;
	localparam int BOUND_BITS = 8;
	localparam int WVAL_BITS  = 8;

	// Stream payload widths (whole bytes)
	localparam int IN_DATA_BITS  = 40;
	localparam int OUT_DATA_BITS = 16;

	// APB register map
	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;
	localparam logic REG_GRID_WIDTH  = 1'b0;
	localparam logic REG_GRID_HEIGHT = 1'b1;

	// Reset values of the geometry registers
	localparam logic [DIM_BITS-1:0] GRID_WIDTH_RST  = DIM_BITS'(10);
	localparam logic [DIM_BITS-1:0] GRID_HEIGHT_RST = DIM_BITS'(10);

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_COUNT = 2'd2,
		CMD_SUM   = 2'd3
	} cmd_t;

	// One command as taken from the input stream
	typedef struct packed {
		cmd_t                  cmd;
		logic [X_BITS-1:0]     pos_x;
		logic [Y_BITS-1:0]     pos_y;
		logic [WVAL_BITS-1:0]  write_value;
		logic [BOUND_BITS-1:0] range_low;
		logic [BOUND_BITS-1:0] range_high;
	} item_t;

	// Effective grid size after clamping
	typedef struct packed {
		logic [DIM_BITS-1:0] used_w;
		logic [DIM_BITS-1:0] used_h;
	} grid_cfg_t;

	// Single-port cell memory request
	typedef struct packed {
		logic                 en;
		logic                 we;
		logic [ADDR_BITS-1:0] addr;
		logic [CELL_BITS-1:0] wdata;
	} mem_req_t;

	// Operands for the shared accumulate/compare unit
	typedef struct packed {
		cmd_t                  op;
		logic                  use_cell;
		logic [CELL_BITS-1:0]  value;
		logic [BOUND_BITS-1:0] lo;
		logic [BOUND_BITS-1:0] hi;
		logic [ANS_BITS-1:0]   acc;
	} alu_req_t;

	// One result item
	typedef struct packed {
		logic                out_of_range;
		logic [ANS_BITS-1:0] answer;
	} result_t;

endpackage

>>> hw/rtl/gnq_cell_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnq_cell_ram
// Single-port cell store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module gnq_cell_ram (
	input  logic                          clk,
	input  gnq_pkg::mem_req_t             req,
	output logic [gnq_pkg::CELL_BITS-1:0] rdata
);

	logic [gnq_pkg::CELL_BITS-1:0] mem [gnq_pkg::MAX_WIDTH*gnq_pkg::MAX_HEIGHT];

	// Write-first is not needed: reads and writes never share a cycle
	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				mem[req.addr] <= req.wdata;
			end
			rdata <= mem[req.addr];
		end
	end

endmodule

>>> hw/rtl/gnq_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnq_alu
// Shared accumulate unit: range compare and count, or add the cell for read and sum.
// ----------------------------------------------------------------------------
module gnq_alu (
	input  gnq_pkg::alu_req_t            req,
	output logic [gnq_pkg::ANS_BITS-1:0] acc_next
);

	logic in_rng;

	assign in_rng = (req.value >= req.lo) && (req.value <= req.hi);

	// Count adds one per matching neighbour; read and sum add the cell
	always_comb begin
		case (req.op)
			gnq_pkg::CMD_COUNT: begin
				acc_next = req.acc + gnq_pkg::ANS_BITS'(req.use_cell && in_rng);
			end
			default: begin
				acc_next = req.acc + gnq_pkg::ANS_BITS'(req.value);
			end
		endcase
	end

endmodule

>>> hw/rtl/gnq_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnq_seq
// Command sequencer: walks the 3x3 window one cell per cycle through the
// memory port, feeds the shared unit and holds the result register.
// ----------------------------------------------------------------------------
module gnq_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  gnq_pkg::item_t                in_item,
	input  gnq_pkg::grid_cfg_t            cfg,
	output gnq_pkg::mem_req_t             mem_req,
	input  logic [gnq_pkg::CELL_BITS-1:0] mem_rdata,
	output gnq_pkg::alu_req_t             alu_req,
	input  logic [gnq_pkg::ANS_BITS-1:0]  acc_next,
	output logic                          out_valid,
	input  logic                          out_ready,
	output gnq_pkg::result_t              out_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_PUSH
	} state_t;

	state_t                         state_q;
	gnq_pkg::item_t                 item_q;
	logic [1:0]                     cx_q;
	logic [1:0]                     cy_q;
	logic [gnq_pkg::ANS_BITS-1:0]   acc_q;
	logic                           flag_q;
	logic                           pend_s1;
	logic                           inb_s1;
	logic                           use_s1;
	logic                           out_valid_q;
	gnq_pkg::result_t               out_q;

	logic [gnq_pkg::DIM_BITS-1:0]   nx;
	logic [gnq_pkg::DIM_BITS-1:0]   ny;
	logic                           inb;
	logic                           last_step;
	logic                           is_window;

	// Neighbour coordinate; stepping left of column 0 wraps high and fails the bound
	assign nx = gnq_pkg::DIM_BITS'(item_q.pos_x) + gnq_pkg::DIM_BITS'(cx_q) -
	            gnq_pkg::DIM_BITS'(1);
	assign ny = gnq_pkg::DIM_BITS'(item_q.pos_y) + gnq_pkg::DIM_BITS'(cy_q) -
	            gnq_pkg::DIM_BITS'(1);
	assign inb = (nx < cfg.used_w) && (ny < cfg.used_h);

	assign is_window = (in_item.cmd == gnq_pkg::CMD_COUNT) ||
	                   (in_item.cmd == gnq_pkg::CMD_SUM);
	assign last_step = (item_q.cmd == gnq_pkg::CMD_WRITE) ||
	                   (item_q.cmd == gnq_pkg::CMD_READ) ||
	                   ((cx_q == 2'd2) && (cy_q == 2'd2));

	// Memory port: off-grid cells are never accessed
	always_comb begin
		mem_req.en    = (state_q == ST_RUN) && inb;
		mem_req.we    = (state_q == ST_RUN) && inb && (item_q.cmd == gnq_pkg::CMD_WRITE);
		mem_req.addr  = {ny[gnq_pkg::Y_BITS-1:0], nx[gnq_pkg::X_BITS-1:0]};
		mem_req.wdata = item_q.write_value[gnq_pkg::CELL_BITS-1:0];
	end

	// Shared unit operands; an off-grid cell reads as zero
	always_comb begin
		alu_req.op       = item_q.cmd;
		alu_req.use_cell = use_s1;
		alu_req.value    = inb_s1 ? mem_rdata : '0;
		alu_req.lo       = item_q.range_low;
		alu_req.hi       = item_q.range_high;
		alu_req.acc      = acc_q;
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Sequencer, read pipeline and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// Result taken; the push state reloads it itself
			if (out_valid_q && out_ready && (state_q != ST_PUSH)) begin
				out_valid_q <= 1'b0;
			end

			pend_s1 <= (state_q == ST_RUN) && (item_q.cmd != gnq_pkg::CMD_WRITE);
			inb_s1  <= inb;
			use_s1  <= !((cx_q == 2'd1) && (cy_q == 2'd1));

			if (pend_s1) begin
				acc_q <= acc_next;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						item_q  <= in_item;
						acc_q   <= '0;
						flag_q  <= 1'b0;
						cx_q    <= is_window ? 2'd0 : 2'd1;
						cy_q    <= is_window ? 2'd0 : 2'd1;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (item_q.cmd == gnq_pkg::CMD_WRITE) begin
						flag_q  <= !inb;
						state_q <= ST_PUSH;
					end else if (last_step) begin
						state_q <= ST_DRAIN;
					end else if (cx_q == 2'd2) begin
						cx_q <= 2'd0;
						cy_q <= cy_q + 2'd1;
					end else begin
						cx_q <= cx_q + 2'd1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q         <= 1'b1;
						out_q.answer        <= acc_q;
						out_q.out_of_range  <= flag_q;
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/grid_neighbourhood_query.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_neighbourhood_query
// Cell grid store with write, read, 3x3 neighbour range count and window sum.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_axis stream, one per transaction; each gives one
//   result transaction on m_axis. Grid width and height are set over APB
//   (byte addresses 0 and 4) while the block is idle; values above 64 act
//   as 64, zero empties the grid.
//   A command passes through the run, drain and push states; a write
//   goes straight from run to push. s_axis_tready rises together with the
//   result valid, so commands do not overlap: the 3x3 window is read one
//   cell per cycle through the single port of the cell memory, and every
//   cell goes through one shared accumulate/compare unit.
//   A finished result sits in the output register; a new command is taken
//   while it waits, and the next result waits in the sequencer until the
//   receiver takes the first.
//   Reset sets width and height to 10 and empties the pipeline; cell
//   contents are undefined until written and read as nothing useful before.
// ----------------------------------------------------------------------------
module grid_neighbourhood_query (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// s_axis_tdata: command[1:0], pos_x[7:2], pos_y[13:8], write_value[21:14],
	//               range_low[29:22], range_high[37:30], zero fill [39:38]
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [gnq_pkg::IN_DATA_BITS-1:0]      s_axis_tdata,
	// m_axis_tdata: answer[11:0], out_of_range[12], zero fill [15:13]
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [gnq_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata,
	// APB configuration port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [gnq_pkg::APB_ADDR_BITS-1:0]     paddr,
	input  logic [gnq_pkg::APB_DATA_BITS-1:0]     pwdata,
	output logic [gnq_pkg::APB_DATA_BITS-1:0]     prdata,
	output logic                                  pready
);

	logic [gnq_pkg::DIM_BITS-1:0]  grid_width_q;
	logic [gnq_pkg::DIM_BITS-1:0]  grid_height_q;
	logic [gnq_pkg::DIM_BITS-1:0]  rd_reg;
	gnq_pkg::grid_cfg_t            cfg;
	gnq_pkg::item_t                in_item;
	gnq_pkg::mem_req_t             mem_req;
	logic [gnq_pkg::CELL_BITS-1:0] mem_rdata;
	gnq_pkg::alu_req_t             alu_req;
	logic [gnq_pkg::ANS_BITS-1:0]  acc_next;
	gnq_pkg::result_t              out_data;

	// APB registers
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= gnq_pkg::GRID_WIDTH_RST;
			grid_height_q <= gnq_pkg::GRID_HEIGHT_RST;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == gnq_pkg::REG_GRID_WIDTH) begin
				grid_width_q <= pwdata[gnq_pkg::DIM_BITS-1:0];
			end else begin
				grid_height_q <= pwdata[gnq_pkg::DIM_BITS-1:0];
			end
		end
	end

	assign rd_reg = (paddr[2] == gnq_pkg::REG_GRID_HEIGHT) ? grid_height_q : grid_width_q;
	assign prdata = gnq_pkg::APB_DATA_BITS'(rd_reg);

	// Clamp geometry to the memory size
	assign cfg.used_w = (grid_width_q > gnq_pkg::DIM_BITS'(gnq_pkg::MAX_WIDTH)) ?
	                    gnq_pkg::DIM_BITS'(gnq_pkg::MAX_WIDTH) : grid_width_q;
	assign cfg.used_h = (grid_height_q > gnq_pkg::DIM_BITS'(gnq_pkg::MAX_HEIGHT)) ?
	                    gnq_pkg::DIM_BITS'(gnq_pkg::MAX_HEIGHT) : grid_height_q;

	// Unpack the command transaction
	assign in_item.cmd         = gnq_pkg::cmd_t'(s_axis_tdata[1:0]);
	assign in_item.pos_x       = s_axis_tdata[7:2];
	assign in_item.pos_y       = s_axis_tdata[13:8];
	assign in_item.write_value = s_axis_tdata[21:14];
	assign in_item.range_low   = s_axis_tdata[29:22];
	assign in_item.range_high  = s_axis_tdata[37:30];

	gnq_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (in_item),
		.cfg       (cfg),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.alu_req   (alu_req),
		.acc_next  (acc_next),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_data)
	);

	gnq_cell_ram u_ram (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	gnq_alu u_alu (
		.req      (alu_req),
		.acc_next (acc_next)
	);

	assign m_axis_tdata = gnq_pkg::OUT_DATA_BITS'(out_data);

	// Checks
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("command accepted while previous command still in progress");

	a_write_only_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.we |-> !s_axis_tready && mem_req.en)
		else $error("cell memory written outside a command");

	a_flag_zero_answer: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[12] |-> m_axis_tdata[11:0] == '0)
		else $error("flagged write returned a nonzero answer");

endmodule
